[hw/rtl/bdlp_pkg.sv]
// Shared types and constants for the button debouncer with long-press events.
// Used by every lane, the merge stage, the output buffer and the top level.
package bdlp_pkg;

  localparam int NumButtons = 2;
  localparam int TimeW      = 32;
  localparam int CfgW       = 16;
  localparam int ButtonW    = 2;
  localparam int CfgIdxW    = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress = 1'd1;

  localparam logic [CfgW-1:0] DebounceReset  = 16'd50;
  localparam logic [CfgW-1:0] LongPressReset = 16'd800;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
  } cfg_t;

  // What one lane found in the current poll
  typedef struct packed {
    logic hit;
    logic long_press;
  } lane_evt_t;

  // One result word
  typedef struct packed {
    logic [ButtonW-1:0] button;
    logic               long_press;
  } result_t;

endpackage

[hw/rtl/bdlp_lane.sv]
// One button lane: debounce timer, stable level, press time and long-press flag.
// Depends on bdlp_pkg; state is written only when the merge stage commits the lane.
module bdlp_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdlp_pkg::cfg_t            cfg_i,
  input  logic [bdlp_pkg::TimeW-1:0] now_ms_i,
  input  logic                      raw_i,
  input  logic                      upd_i,
  output bdlp_pkg::lane_evt_t       evt_o
);
  import bdlp_pkg::*;

  logic             stable_q, stable_d;
  logic             last_q, last_d;
  logic [TimeW-1:0] edge_q, edge_d;
  logic [TimeW-1:0] press_q, press_d;
  logic             long_q, long_d;
  logic [TimeW-1:0] since_edge;
  logic [TimeW-1:0] since_press;
  logic             settled;

  always_comb begin
    last_d      = raw_i;
    edge_d      = (raw_i != last_q) ? now_ms_i : edge_q;
    since_edge  = now_ms_i - edge_d;
    since_press = now_ms_i - press_q;
    settled     = since_edge >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_ms};
    stable_d    = stable_q;
    press_d     = press_q;
    long_d      = long_q;
    evt_o       = '0;
    if (settled) begin
      if (raw_i != stable_q) begin
        stable_d = raw_i;
        if (!raw_i) begin
          press_d = now_ms_i;
          long_d  = 1'b0;
        end else if (!long_q) begin
          evt_o.hit = 1'b1;
        end
      end else if (!raw_i && !long_q &&
                   since_press >= {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms}) begin
        long_d           = 1'b1;
        evt_o.hit        = 1'b1;
        evt_o.long_press = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      last_q   <= 1'b1;
      edge_q   <= '0;
      press_q  <= '0;
      long_q   <= 1'b0;
    end else if (upd_i) begin
      stable_q <= stable_d;
      last_q   <= last_d;
      edge_q   <= edge_d;
      press_q  <= press_d;
      long_q   <= long_d;
    end
  end

endmodule

[hw/rtl/bdlp_merge.sv]
// Merge stage: the lowest-numbered lane with an event wins the poll.
// Depends on bdlp_pkg; lanes above the winner are held for this poll.
module bdlp_merge (
  input  bdlp_pkg::lane_evt_t [bdlp_pkg::NumButtons-1:0] evt_i,
  output logic [bdlp_pkg::NumButtons-1:0]                commit_o,
  output bdlp_pkg::result_t                              res_o
);
  import bdlp_pkg::*;

  logic seen;

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < NumButtons; i++) begin
      commit_o[i] = !seen;
      seen        = seen | evt_i[i].hit;
    end
  end

  // Scan downwards so that the lowest hit is written last
  always_comb begin
    res_o = '0;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (evt_i[i].hit) begin
        res_o.button     = ButtonW'(i + 1);
        res_o.long_press = evt_i[i].long_press;
      end
    end
  end

endmodule

[hw/rtl/bdlp_outbuf.sv]
// Two-word output buffer between the merge stage and the result channel.
// Depends on bdlp_pkg; stall towards the input is taken from the fill count alone.
module bdlp_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bdlp_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output bdlp_pkg::result_t data_o
);
  import bdlp_pkg::*;

  logic [1:0] count_q, count_d;
  result_t    head_q, head_d;
  result_t    tail_q, tail_d;
  logic       pop;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign data_o  = head_q;
  assign pop     = valid_o && !stall_i;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
    case (count_q)
      2'd0: begin
        if (push_i) head_d = data_i;
      end
      2'd1: begin
        if (pop && push_i) head_d = data_i;
        else if (push_i)   tail_d = data_i;
      end
      2'd2: begin
        if (pop) head_d = tail_q;
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

[hw/rtl/button_debounce_long_press_core.sv]
// Button debouncer with short- and long-press events, one lane per button.
// A result word enters the output buffer when its poll is accepted and is offered once the words ahead of it are taken.
// Throughput: one poll per cycle unless stalled; lanes and merge are combinational,
// and a two-word output buffer lets polls go on while results wait, until it is full.
// Reset: all buttons released, timers cleared, debounce 50 ms, long press 800 ms.
module button_debounce_long_press_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bdlp_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bdlp_pkg::TimeW-1:0]          now_ms_i,
  input  logic [bdlp_pkg::NumButtons-1:0]     raw_levels_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bdlp_pkg::ButtonW-1:0]        button_o,
  output logic                                long_press_o
);
  import bdlp_pkg::*;

  cfg_t                       cfg_q;
  logic                       accept;
  lane_evt_t [NumButtons-1:0] evt;
  logic [NumButtons-1:0]      commit;
  result_t                    res;
  result_t                    out_word;
  logic                       full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceReset;
      cfg_q.long_press_ms <= LongPressReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce:  cfg_q.debounce_ms   <= cfg_data_i;
        RegLongPress: cfg_q.long_press_ms <= cfg_data_i;
        default:      cfg_q               <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    bdlp_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cfg_i    (cfg_q),
      .now_ms_i (now_ms_i),
      .raw_i    (raw_levels_i[g]),
      .upd_i    (accept && commit[g]),
      .evt_o    (evt[g])
    );
  end

  bdlp_merge u_merge (
    .evt_i    (evt),
    .commit_o (commit),
    .res_o    (res)
  );

  bdlp_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_word)
  );

  assign button_o     = out_word.button;
  assign long_press_o = out_word.long_press;

endmodule

[hw/rtl/bdlp_checker.sv]
// Port-level checks for the button debouncer core, attached by bind.
// Depends on bdlp_pkg for the button count.
module bdlp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [bdlp_pkg::ButtonW-1:0] button_o,
  input logic                         long_press_o
);
  import bdlp_pkg::*;

  // A stalled result word stays on offer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // No word appears without an accepted poll or one already waiting
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result word without a poll");

  // Input is held back only while results are waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // An empty result carries no long-press flag, and the button is in range
  a_word_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(button_o) <= NumButtons) && (button_o != '0 || !long_press_o))
    else $error("malformed result word");

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (.*);

[test/button_debounce_long_press_core_tb.sv]
// Self-checking testbench for button_debounce_long_press_core.
// Depends on bdlp_pkg and the core. Each accepted poll is predicted in the bench, and
// every result word is checked in order against that prediction.
module button_debounce_long_press_core_tb;
  import bdlp_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [CfgW-1:0]       cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [TimeW-1:0]      now_ms_i;
  logic [NumButtons-1:0] raw_levels_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ButtonW-1:0]    button_o;
  logic                  long_press_o;

  button_debounce_long_press_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .now_ms_i     (now_ms_i),
    .raw_levels_i (raw_levels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .button_o     (button_o),
    .long_press_o (long_press_o)
  );

  // Bench copy of the debouncer state and its registers
  logic [CfgW-1:0]  debounce_cfg;
  logic [CfgW-1:0]  long_cfg;
  logic             stable_lvl [NumButtons];
  logic             last_lvl   [NumButtons];
  logic [TimeW-1:0] edge_at    [NumButtons];
  logic [TimeW-1:0] pressed_at [NumButtons];
  logic             long_done  [NumButtons];

  result_t pending_events [$];
  int      mismatches;
  int      words_taken;
  int      words_seen;
  int      stall_left;
  bit      calm;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void clear_model();
    debounce_cfg = DebounceReset;
    long_cfg     = LongPressReset;
    for (int i = 0; i < NumButtons; i++) begin
      stable_lvl[i] = 1'b1;
      last_lvl[i]   = 1'b1;
      edge_at[i]    = '0;
      pressed_at[i] = '0;
      long_done[i]  = 1'b0;
    end
  endfunction

  // Scan the buttons in order; the first event ends the scan
  function automatic result_t predict_poll(input logic [TimeW-1:0] now,
                                           input logic [NumButtons-1:0] lv);
    result_t          r;
    logic             b;
    logic [TimeW-1:0] held;
    r = '0;
    for (int i = 0; i < NumButtons; i++) begin
      b = lv[i];
      if (b != last_lvl[i]) begin
        last_lvl[i] = b;
        edge_at[i]  = now;
      end
      held = now - edge_at[i];
      if (held < {16'd0, debounce_cfg}) continue;
      if (b != stable_lvl[i]) begin
        stable_lvl[i] = b;
        if (!b) begin
          pressed_at[i] = now;
          long_done[i]  = 1'b0;
        end else if (!long_done[i]) begin
          r.button = ButtonW'(i + 1);
          return r;
        end
      end else if (!b && !long_done[i] && (now - pressed_at[i]) >= {16'd0, long_cfg}) begin
        long_done[i]  = 1'b1;
        r.button      = ButtonW'(i + 1);
        r.long_press  = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  // Called just after a falling edge; returns just after a falling edge, once the poll has been accepted
  task automatic send_poll(input logic [TimeW-1:0] now, input logic [NumButtons-1:0] lv);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    now_ms_i     <= now;
    raw_levels_i <= lv;
    do @(posedge clk_i); while (in_stall_o);
    pending_events.push_back(predict_poll(now, lv));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegDebounce:  debounce_cfg = val;
      RegLongPress: long_cfg     = val;
      default: ;
    endcase
  endtask

  // Reset values: press, bounce, long press, short press, both buttons at once
  task automatic test_default_timing();
    send_poll(32'd1000, 2'b11);
    send_poll(32'd1000, 2'b10);
    send_poll(32'd1049, 2'b10);
    send_poll(32'd1050, 2'b10);
    send_poll(32'd1849, 2'b10);
    send_poll(32'd1850, 2'b10);
    send_poll(32'd1900, 2'b11);
    send_poll(32'd1950, 2'b11);
    send_poll(32'd2000, 2'b01);
    send_poll(32'd2050, 2'b01);
    send_poll(32'd2100, 2'b11);
    send_poll(32'd2150, 2'b11);
    // both held: the second button only reports on the following poll
    send_poll(32'd3000, 2'b00);
    send_poll(32'd3050, 2'b00);
    send_poll(32'd3850, 2'b00);
    send_poll(32'd3851, 2'b00);
    send_poll(32'd4050, 2'b11);
    send_poll(32'd4100, 2'b11);
  endtask

  // Timestamps that step backwards or cross the 32-bit wrap
  task automatic test_time_wrap();
    send_poll(32'd100, 2'b10);
    send_poll(32'd50, 2'b10);
    send_poll(32'hFFFF_FFF0, 2'b11);
    send_poll(32'hFFFF_FFF8, 2'b11);
    send_poll(32'h0000_0030, 2'b11);
  endtask

  task automatic test_zero_times();
    write_reg(RegDebounce, 16'd0);
    write_reg(RegLongPress, 16'd0);
    send_poll(32'd10, 2'b10);
    send_poll(32'd10, 2'b10);
    send_poll(32'd11, 2'b11);
    send_poll(32'd12, 2'b01);
    send_poll(32'd13, 2'b11);
  endtask

  task automatic test_max_times();
    logic [TimeW-1:0] t0;
    t0 = 32'hFFFF_0000;
    write_reg(RegDebounce, 16'hFFFF);
    write_reg(RegLongPress, 16'hFFFF);
    send_poll(t0, 2'b01);
    send_poll(t0 + 32'd65534, 2'b01);
    send_poll(t0 + 32'd65535, 2'b01);
    send_poll(t0 + 32'd131069, 2'b01);
    send_poll(t0 + 32'd131070, 2'b01);
  endtask

  // Mostly plausible button activity with advancing time; some polls are pure noise
  task automatic test_random_phase(input int n, input logic [CfgW-1:0] deb,
                                   input logic [CfgW-1:0] lng);
    logic [TimeW-1:0]      t;
    logic [NumButtons-1:0] lv;
    int                    span;
    write_reg(RegDebounce, deb);
    write_reg(RegLongPress, lng);
    t    = $urandom();
    lv   = '1;
    span = int'(deb) + int'(lng);
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_poll($urandom(), NumButtons'($urandom_range(0, 3)));
      end else begin
        if ($urandom_range(0, 7) == 0) t = t + $urandom_range(span / 2, span + 2);
        else t = t + $urandom_range(0, span / 8 + 2);
        for (int i = 0; i < NumButtons; i++)
          if ($urandom_range(0, 4) == 0) lv[i] = ~lv[i];
        send_poll(t, lv);
      end
    end
    calm = 1'b0;
  endtask

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_taken <= words_taken + 1;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected word, expected none, got button=%0d long_press=%0b",
                 $time, button_o, long_press_o);
        mismatches <= mismatches + 1;
      end else begin
        if (pending_events[0].button != button_o ||
            pending_events[0].long_press != long_press_o) begin
          $display({"%0t: mismatch expected button=%0d long_press=%0b, ",
                    "got button=%0d long_press=%0b"},
                   $time, pending_events[0].button, pending_events[0].long_press,
                   button_o, long_press_o);
          mismatches <= mismatches + 1;
        end
        void'(pending_events.pop_front());
      end
    end
  end

  // Draw a fresh stall after each taken word
  always @(negedge clk_i) begin
    if (words_seen != words_taken) begin
      words_seen = words_taken;
      stall_left = calm ? 0 : $urandom_range(0, 7);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegDebounce;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    now_ms_i     = '0;
    raw_levels_i = '1;
    out_stall_i  = 1'b0;
    mismatches   = 0;
    words_taken  = 0;
    words_seen   = 0;
    stall_left   = 0;
    calm         = 1'b0;
    clear_model();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_timing();
    test_time_wrap();
    test_zero_times();
    test_max_times();
    test_random_phase(120, 16'd0, 16'd0);
    test_random_phase(120, 16'hFFFF, 16'hFFFF);
    test_random_phase(120, 16'd0, 16'hFFFF);
    test_random_phase(120, 16'hFFFF, 16'd0);
    test_random_phase(120, 16'd5, 16'd20);
    test_random_phase(120, 16'd1, 16'd3);
    test_random_phase(120, CfgW'($urandom_range(0, 30)), CfgW'($urandom_range(0, 200)));
    test_random_phase(120, DebounceReset, LongPressReset);

    drain();
    repeat (5) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[button_debounce_long_press_core] OK");
    end else begin
      $display("[button_debounce_long_press_core] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[button_debounce_long_press_core] ERROR");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_lane.sv
hw/rtl/bdlp_merge.sv
hw/rtl/bdlp_outbuf.sv
hw/rtl/button_debounce_long_press_core.sv
hw/rtl/bdlp_checker.sv
test/button_debounce_long_press_core_tb.sv
